### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define CHK_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// trigger in one cycle implies the consequence in the next
`define CHK_NEXT(name, clk, rst, trig, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/uecg_pkg.sv
`default_nettype none
package uecg_pkg;

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [7:0] BACKSLASH = 8'h5C;

   // classified byte handed from the front to the back
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] cont;      // continuation bytes announced, 0 when not a lead
      logic       is_bs;
      logic [7:0] esc_word;  // value if this byte follows a backslash
   } class_type;

endpackage
`default_nettype wire

### hdl/utf8_escape_char_grouper.sv
// channel  | direction | handshake            | payload
// req      | in        | req_valid, req_stall | req_byte_in, req_last_byte
// rsp      | out       | rsp_valid, rsp_stall | rsp_char_word, rsp_has_char,
//          |           |                      | rsp_end_of_string, rsp_truncated
//
// one byte accepted per cycle while req_stall is low; a result passes through the
// classify register, the four-entry queue and the output register
// bytes that finish no character and are not last give no result
// reset is synchronous and clears all control and grouping state
// a stalled result holds; bytes keep entering until the queue fills
`default_nettype none
module utf8_escape_char_grouper
   import uecg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_byte_in,
   input  wire logic        req_last_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_char_word,
   output      logic        rsp_has_char,
   output      logic        rsp_end_of_string,
   output      logic        rsp_truncated
);

   logic      cls_valid;
   logic      cls_full;
   class_type cls_item;
   logic      head_valid;
   class_type head_item;
   logic      pop;

   uecg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_byte_in   (req_byte_in),
      .req_last_byte (req_last_byte),
      .cls_valid     (cls_valid),
      .cls_full      (cls_full),
      .cls_item      (cls_item)
   );

   uecg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cls_valid),
      .push_item  (cls_item),
      .full       (cls_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   uecg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_word     (rsp_char_word),
      .rsp_has_char      (rsp_has_char),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_truncated     (rsp_truncated)
   );

endmodule
`default_nettype wire

### hdl/uecg_front.sv
`default_nettype none
module uecg_front
   import uecg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_byte_in,
   input  wire logic       req_last_byte,
   output      logic       cls_valid,
   input  wire logic       cls_full,
   output      class_type  cls_item
);

   logic      valid_ff;
   class_type item_ff;
   class_type item_in;
   logic      adv;

   function automatic logic [1:0] cont_count(input logic [7:0] b);
      logic [1:0] n;
      n = 2'd0;
      if (b >= 8'hC2 && b <= 8'hDF) n = 2'd1;
      else if (b >= 8'hE0 && b <= 8'hEF) n = 2'd2;
      else if (b >= 8'hF0 && b <= 8'hF4) n = 2'd3;
      return n;
   endfunction

   function automatic logic [7:0] escape_map(input logic [7:0] b);
      logic [7:0] v;
      case (b)
         8'h61: v = 8'h07;   // a
         8'h62: v = 8'h08;   // b
         8'h66: v = 8'h0C;   // f
         8'h6E: v = 8'h0A;   // n
         8'h72: v = 8'h0D;   // r
         8'h74: v = 8'h09;   // t
         8'h76: v = 8'h0B;   // v
         8'h0A: v = 8'h00;   // escaped newline gives nothing
         default: v = b;
      endcase
      return v;
   endfunction

   always_comb begin
      item_in.data     = req_byte_in;
      item_in.last     = req_last_byte;
      item_in.cont     = cont_count(req_byte_in);
      item_in.is_bs    = (req_byte_in == BACKSLASH);
      item_in.esc_word = escape_map(req_byte_in);
   end

   // stage moves when empty or when the queue takes its item
   assign adv       = !valid_ff || !cls_full;
   assign req_stall = !adv;
   assign cls_valid = valid_ff;
   assign cls_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= req_valid;
      end
      if (adv && req_valid) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

### hdl/uecg_queue.sv
`default_nettype none
module uecg_queue
   import uecg_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire class_type push_item,
   output      logic      full,
   input  wire logic      pop,
   output      logic      head_valid,
   output      class_type head_item
);

   class_type           mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff;
   logic [QPTR_W-1:0]   rd_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic                do_push;
   logic                do_pop;

   assign full       = (cnt_ff == QCNT_W'(QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = mem[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + QPTR_W'(1);
         if (do_pop) rd_ff <= rd_ff + QPTR_W'(1);
         if (do_push && !do_pop) cnt_ff <= cnt_ff + QCNT_W'(1);
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

### hdl/uecg_back.sv
`default_nettype none
module uecg_back
   import uecg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        head_valid,
   input  wire class_type   head_item,
   output      logic        pop,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_char_word,
   output      logic        rsp_has_char,
   output      logic        rsp_end_of_string,
   output      logic        rsp_truncated
);

   typedef enum logic [1:0] {PH_NONE, PH_BS, PH_SKIP} phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  left_ff, left_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  escv_ff, escv_in;
   logic        valid_ff;
   logic [31:0] word_ff;
   logic        has_ff, eos_ff, trunc_ff;

   logic [31:0] acc_next;
   logic [31:0] word;
   logic        emit;
   logic        pending;
   logic        out_free;

   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = head_valid && out_free;

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      acc_in   = acc_ff;
      escv_in  = escv_ff;
      acc_next = {acc_ff[23:0], head_item.data};
      word     = '0;
      emit     = 1'b0;
      case (phase_ff)
         PH_BS: begin
            if (head_item.cont != 2'd0) begin
               escv_in  = head_item.data;
               left_in  = {1'b0, head_item.cont};
               phase_in = PH_SKIP;
            end else begin
               word     = {24'd0, head_item.esc_word};
               emit     = (head_item.esc_word != 8'd0);
               phase_in = PH_NONE;
            end
         end
         PH_SKIP: begin
            if (left_ff > 3'd1) begin
               left_in = left_ff - 3'd1;
            end else begin
               left_in  = '0;
               word     = {24'd0, escv_ff};
               emit     = (escv_ff != 8'd0);
               phase_in = PH_NONE;
            end
         end
         default: begin
            phase_in = PH_NONE;
            if (left_ff != 3'd0) begin
               left_in = left_ff - 3'd1;
               if (left_ff == 3'd1) begin
                  word   = acc_next;
                  emit   = (acc_next != 32'd0);
                  acc_in = '0;
               end else begin
                  acc_in = acc_next;
               end
            end else if (head_item.is_bs) begin
               phase_in = PH_BS;
            end else if (head_item.cont != 2'd0) begin
               acc_in  = {24'd0, head_item.data};
               left_in = {1'b0, head_item.cont};
            end else begin
               word = {24'd0, head_item.data};
               emit = (head_item.data != 8'd0);
            end
         end
      endcase
      pending = (phase_in != PH_NONE) || (left_in != 3'd0);
      // the end of a string puts everything back to reset
      if (head_item.last) begin
         phase_in = PH_NONE;
         left_in  = '0;
         acc_in   = '0;
         escv_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NONE;
         left_ff  <= '0;
         acc_ff   <= '0;
         escv_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
            acc_ff   <= acc_in;
            escv_ff  <= escv_in;
         end
         if (pop && (emit || head_item.last)) begin
            valid_ff <= 1'b1;
         end else if (out_free) begin
            valid_ff <= 1'b0;
         end
      end
      if (pop && (emit || head_item.last)) begin
         word_ff  <= emit ? word : 32'd0;
         has_ff   <= emit;
         eos_ff   <= head_item.last;
         trunc_ff <= head_item.last && pending;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_char_word     = word_ff;
   assign rsp_has_char      = has_ff;
   assign rsp_end_of_string = eos_ff;
   assign rsp_truncated     = trunc_ff;

endmodule
`default_nettype wire

### hdl/uecg_checker.sv
`default_nettype none
`include "assert_macros.svh"
module uecg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_byte_in,
   input wire logic        req_last_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_char_word,
   input wire logic        rsp_has_char,
   input wire logic        rsp_end_of_string,
   input wire logic        rsp_truncated
);

   // a character item never carries a zero word, an empty one always does
   `CHK_ALWAYS(a_char_nonzero, clock, reset, !rsp_valid || (rsp_has_char == (rsp_char_word != 32'd0)))
   // an item without a character only closes a string
   `CHK_ALWAYS(a_empty_is_end, clock, reset, !rsp_valid || rsp_has_char || rsp_end_of_string)
   // truncation is reported only at the end of a string
   `CHK_ALWAYS(a_trunc_at_end, clock, reset, !rsp_valid || !rsp_truncated || rsp_end_of_string)
   // a stalled result stays valid and holds its word and end-of-string flag
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_char_word) && $stable(rsp_end_of_string))

endmodule

bind utf8_escape_char_grouper uecg_checker u_checker (.*);
`default_nettype wire
